/* design/midi_host_port_with_rx_ring_top_macros.svh */
// ----------------------------------------------------------------------------
// MIDI host port assertion macros
// Shared assertion macros. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MIDI_HOST_PORT_WITH_RX_RING_TOP_MACROS_SVH
`define MIDI_HOST_PORT_WITH_RX_RING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MHP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define MHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define MHP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/mhp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI host port package
// Shared types, codes and constants of the MIDI host port with receive ring.
// ----------------------------------------------------------------------------
package mhp_pkg;

   localparam int BYTE_W         = 8;
   localparam int OP_W           = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 1;
   localparam int RING_DEPTH_DEF = 256;

   // Event codes carried in the operation field.
   typedef enum logic [OP_W-1:0] {
      OP_DATA_READ   = 2'd0,
      OP_STATUS_READ = 2'd1,
      OP_HOST_WRITE  = 2'd2,
      OP_MIDI_RX     = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOST_TO_MIDI_OUT = 2'd0,
      CSR_HOST_TO_AUX      = 2'd1,
      CSR_RX_TO_MIDI_OUT   = 2'd2,
      CSR_RX_TO_AUX        = 2'd3
   } csr_index_type;

   // Back end sequencer states.
   typedef enum logic {
      BK_EXEC = 1'b0,
      BK_READ_WAIT = 1'b1
   } back_state_type;

   // One classified event as held in the queue.
   typedef struct packed {
      op_type                 op;
      logic [BYTE_W-1:0]      data;
   } item_type;

   // Transmitter routing controls.
   typedef struct packed {
      logic host_to_midi_out;
      logic host_to_aux;
      logic rx_to_midi_out;
      logic rx_to_aux;
   } route_type;

   // Receive ring status seen by the top level.
   typedef struct packed {
      logic              avail;
      logic              ptr_match;
      logic [BYTE_W-1:0] cur_byte;
   } ring_status_type;

endpackage

/* design/mhp_ram.sv */
// ----------------------------------------------------------------------------
// MIDI host port generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mhp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mhp_front.sv */
// ----------------------------------------------------------------------------
// MIDI host port front end
// Accepts request transfers, decodes the event code and queues the event
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mhp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mhp_pkg::OP_W-1:0]  req_operation,
   input  logic [mhp_pkg::BYTE_W-1:0] req_byte_in,
   output logic                      head_valid,
   output mhp_pkg::item_type         head_item,
   input  logic                      head_pop
);

   mhp_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   mhp_pkg::item_type new_item;

   // Classify the incoming event.
   always_comb begin
      new_item.op   = mhp_pkg::op_type'(req_operation);
      new_item.data = req_byte_in;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_pop && head_valid;
   assign head_item  = q_ff[rd_ptr_ff];

   // Queue pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* design/mhp_back.sv */
// ----------------------------------------------------------------------------
// MIDI host port back end
// Carries out queued events against the receive ring and drives the
// response register.
// ----------------------------------------------------------------------------
module mhp_back #(
   parameter int RING_DEPTH = mhp_pkg::RING_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  mhp_pkg::item_type           head_item,
   output logic                        head_pop,
   input  mhp_pkg::route_type          route,
   output mhp_pkg::ring_status_type    status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mhp_pkg::BYTE_W-1:0]  rsp_read_value,
   output logic                        rsp_midi_out_valid,
   output logic [mhp_pkg::BYTE_W-1:0]  rsp_midi_out_byte,
   output logic                        rsp_aux_valid,
   output logic [mhp_pkg::BYTE_W-1:0]  rsp_aux_byte
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   mhp_pkg::back_state_type     state_ff, state_in;
   logic [PTR_W-1:0]            rp_ff, rp_in;
   logic [PTR_W-1:0]            wp_ff, wp_in;
   logic                        avail_ff, avail_in;
   logic [mhp_pkg::BYTE_W-1:0]  cur_ff, cur_in;
   logic                        is_data_ff, is_data_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mhp_pkg::BYTE_W-1:0]  rv_ff, rv_in;
   logic                        mo_v_ff, mo_v_in;
   logic [mhp_pkg::BYTE_W-1:0]  mo_b_ff, mo_b_in;
   logic                        ax_v_ff, ax_v_in;
   logic [mhp_pkg::BYTE_W-1:0]  ax_b_ff, ax_b_in;

   logic                        out_free;
   logic                        load_out;
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [PTR_W-1:0]            ram_rd_addr;
   logic [mhp_pkg::BYTE_W-1:0]  ram_rd_data;
   logic [PTR_W-1:0]            rp_step;

   // Receive ring storage.
   mhp_ram #(
      .WIDTH (mhp_pkg::BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (head_item.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rp_step  = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;

   // Sequencer: next state, ring updates and response payload.
   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      avail_in    = avail_ff;
      cur_in      = cur_ff;
      is_data_in  = is_data_ff;
      head_pop    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rp_ff;
      load_out    = 1'b0;
      rv_in       = rv_ff;
      mo_v_in     = mo_v_ff;
      mo_b_in     = mo_b_ff;
      ax_v_in     = ax_v_ff;
      ax_b_in     = ax_b_ff;

      case (state_ff)
         mhp_pkg::BK_EXEC: begin
            if (head_valid) begin
               case (head_item.op)
                  mhp_pkg::OP_DATA_READ: begin
                     // Step past the delivered byte and fetch the next one.
                     head_pop   = 1'b1;
                     is_data_in = 1'b1;
                     if (avail_ff) begin
                        rp_in    = rp_step;
                        avail_in = (rp_step != wp_ff);
                     end
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = rp_in;
                     state_in    = mhp_pkg::BK_READ_WAIT;
                  end
                  mhp_pkg::OP_STATUS_READ: begin
                     head_pop    = 1'b1;
                     is_data_in  = 1'b0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = rp_ff;
                     state_in    = mhp_pkg::BK_READ_WAIT;
                  end
                  mhp_pkg::OP_HOST_WRITE: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        load_out = 1'b1;
                        rv_in    = '0;
                        mo_v_in  = route.host_to_midi_out;
                        mo_b_in  = route.host_to_midi_out ? head_item.data : '0;
                        ax_v_in  = route.host_to_aux;
                        ax_b_in  = route.host_to_aux ? head_item.data : '0;
                     end
                  end
                  default: begin
                     // Received byte: store, advance, echo as routed.
                     if (out_free) begin
                        head_pop  = 1'b1;
                        load_out  = 1'b1;
                        ram_wr_en = 1'b1;
                        wp_in     = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
                        avail_in  = 1'b1;
                        rv_in     = '0;
                        mo_v_in   = route.rx_to_midi_out;
                        mo_b_in   = route.rx_to_midi_out ? head_item.data : '0;
                        ax_v_in   = route.rx_to_aux;
                        ax_b_in   = route.rx_to_aux ? head_item.data : '0;
                     end
                  end
               endcase
            end
         end
         mhp_pkg::BK_READ_WAIT: begin
            // Ring data has arrived; finish the read once the response
            // register can take it.
            if (out_free) begin
               load_out = 1'b1;
               mo_v_in  = 1'b0;
               mo_b_in  = '0;
               ax_v_in  = 1'b0;
               ax_b_in  = '0;
               if (is_data_ff) begin
                  rv_in  = cur_ff;
                  cur_in = avail_ff ? ram_rd_data : '0;
               end else begin
                  rv_in  = {{(mhp_pkg::BYTE_W-1){1'b0}}, avail_ff};
                  cur_in = avail_ff ? ram_rd_data : cur_ff;
               end
               state_in = mhp_pkg::BK_EXEC;
            end
         end
         default: begin
            state_in = mhp_pkg::BK_EXEC;
         end
      endcase

      rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Control and ring state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhp_pkg::BK_EXEC;
         rp_ff        <= '0;
         wp_ff        <= '0;
         avail_ff     <= 1'b0;
         cur_ff       <= '0;
         is_data_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         avail_ff     <= avail_in;
         cur_ff       <= cur_in;
         is_data_ff   <= is_data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rv_ff   <= rv_in;
         mo_v_ff <= mo_v_in;
         mo_b_ff <= mo_b_in;
         ax_v_ff <= ax_v_in;
         ax_b_ff <= ax_b_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rv_ff;
   assign rsp_midi_out_valid = mo_v_ff;
   assign rsp_midi_out_byte  = mo_b_ff;
   assign rsp_aux_valid      = ax_v_ff;
   assign rsp_aux_byte       = ax_b_ff;

   assign status.avail     = avail_ff;
   assign status.ptr_match = (rp_ff == wp_ff);
   assign status.cur_byte  = cur_ff;

endmodule

/* design/midi_host_port_with_rx_ring_top.sv */
// ----------------------------------------------------------------------------
// MIDI host port with receive ring
// Host bus MIDI interface: received bytes go to a ring, host reads drain it,
// host writes and received bytes are routed to the two transmitters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_operation, req_byte_in
// rsp       out        rsp_valid/rsp_ready    read value, two transmitter bytes
// csr       in         csr_write_en           csr_index, csr_wdata
//
// A host write or a received byte is done in the execute state; a data or
// status read also passes the read-wait state, as the ring read is registered.
// A two-entry queue sits between the front and back ends. The back end stalls
// while the response register still holds a result that has not been taken;
// a read may issue its ring access first and then waits for the register.
// Reset is synchronous; the ring contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
`include "midi_host_port_with_rx_ring_top_macros.svh"

module midi_host_port_with_rx_ring_top #(
   parameter int RING_DEPTH = mhp_pkg::RING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mhp_pkg::OP_W-1:0]         req_operation,
   input  logic [mhp_pkg::BYTE_W-1:0]       req_byte_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mhp_pkg::BYTE_W-1:0]       rsp_read_value,
   output logic                             rsp_midi_out_valid,
   output logic [mhp_pkg::BYTE_W-1:0]       rsp_midi_out_byte,
   output logic                             rsp_aux_valid,
   output logic [mhp_pkg::BYTE_W-1:0]       rsp_aux_byte,
   input  logic                             csr_write_en,
   input  logic [mhp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mhp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   mhp_pkg::route_type       route_ff, route_in;
   mhp_pkg::item_type        head_item;
   mhp_pkg::ring_status_type status;
   logic                     head_valid;
   logic                     head_pop;

   // Routing registers.
   always_comb begin
      route_in = route_ff;
      if (csr_write_en) begin
         case (mhp_pkg::csr_index_type'(csr_index))
            mhp_pkg::CSR_HOST_TO_MIDI_OUT: route_in.host_to_midi_out = csr_wdata[0];
            mhp_pkg::CSR_HOST_TO_AUX:      route_in.host_to_aux      = csr_wdata[0];
            mhp_pkg::CSR_RX_TO_MIDI_OUT:   route_in.rx_to_midi_out   = csr_wdata[0];
            mhp_pkg::CSR_RX_TO_AUX:        route_in.rx_to_aux        = csr_wdata[0];
            default:                       route_in = route_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_ff <= '0;
      end else begin
         route_ff <= route_in;
      end
   end

   // Front end: accept and queue.
   mhp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_byte_in   (req_byte_in),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   // Back end: ring operations and responses.
   mhp_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .head_pop           (head_pop),
      .route              (route_ff),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_midi_out_valid (rsp_midi_out_valid),
      .rsp_midi_out_byte  (rsp_midi_out_byte),
      .rsp_aux_valid      (rsp_aux_valid),
      .rsp_aux_byte       (rsp_aux_byte)
   );

   // An empty ring always has its pointers together.
   `MHP_ASSERT_IMPLY(a_empty_ptrs, clock, reset, !status.avail, status.ptr_match)
   // A waiting response keeps its valid and its read value.
   `MHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value))
   // An idle transmitter lane carries a zero byte.
   `MHP_ASSERT_IMPLY(a_idle_lanes, clock, reset, rsp_valid,
      (rsp_midi_out_valid || rsp_midi_out_byte == '0) && (rsp_aux_valid || rsp_aux_byte == '0))

endmodule
